// ===== sv/rrb_pkg.sv =====
// Shared constants and payload types for the rotated rectangle bounds block.
package rrb_pkg;

  // Coordinate and angle formats of the ports.
  localparam int CoordBits = 24;
  localparam int AngleBits = 16;

  // Default depth of the quarter-wave sine table (entries 0..depth).
  localparam int TrigTableDepth = 1024;

  // Trig values are unsigned Q1.16 magnitudes, 65536 = 1.0.
  localparam int TrigFracBits = 16;
  localparam int TrigBits     = TrigFracBits + 1;

  // One rectangle to transform.
  typedef struct packed {
    logic signed [CoordBits-1:0] rect_x;
    logic signed [CoordBits-1:0] rect_y;
    logic        [CoordBits-2:0] rect_width;
    logic        [CoordBits-2:0] rect_height;
    logic        [AngleBits-1:0] angle;
  } rrb_in_t;

  // Bounding box and the four rotated corners.
  typedef struct packed {
    logic signed [CoordBits-1:0] bound_x;
    logic signed [CoordBits-1:0] bound_y;
    logic        [CoordBits-2:0] bound_width;
    logic        [CoordBits-2:0] bound_height;
    logic signed [CoordBits-1:0] top_left_x;
    logic signed [CoordBits-1:0] top_left_y;
    logic signed [CoordBits-1:0] top_right_x;
    logic signed [CoordBits-1:0] top_right_y;
    logic signed [CoordBits-1:0] bottom_right_x;
    logic signed [CoordBits-1:0] bottom_right_y;
    logic signed [CoordBits-1:0] bottom_left_x;
    logic signed [CoordBits-1:0] bottom_left_y;
  } rrb_out_t;

endpackage

// ===== sv/rrb_trig_rom.sv =====
// Quarter-wave sine ROM with two registered read ports.
module rrb_trig_rom #(
  parameter int TRIG_TABLE_DEPTH = rrb_pkg::TrigTableDepth
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [$clog2(TRIG_TABLE_DEPTH+1)-1:0] addr_a_i,
  input  logic [$clog2(TRIG_TABLE_DEPTH+1)-1:0] addr_b_i,
  output logic [rrb_pkg::TrigBits-1:0]          data_a_o,
  output logic [rrb_pkg::TrigBits-1:0]          data_b_o
);

  // Fixed-point constants of the table generator (angles in Q2.30).
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1073741824;
  localparam logic [63:0] TrigOne   = 64'd65536;
  localparam logic [63:0] RoundQ29  = 64'd536870912;
  localparam int          NumTerms  = 12;

  // Taylor term divisors (2n)*(2n+1).
  localparam logic [63:0] TermDiv [1:NumTerms] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  logic [rrb_pkg::TrigBits-1:0] rom_table [0:TRIG_TABLE_DEPTH];

  // Entry k is sin(pi/2 * k / depth) in Q1.16, from a truncated Taylor series.
  function automatic logic [rrb_pkg::TrigBits-1:0] sine_entry(input int unsigned k);
    logic        [63:0] th;
    logic        [63:0] term;
    logic signed [63:0] acc;
    logic        [63:0] r;
    th   = (HalfPiQ30 * 64'(k)) / 64'(TRIG_TABLE_DEPTH);
    term = th;
    acc  = $signed(th);
    for (int n = 1; n <= NumTerms; n++) begin
      term = (term * th) >> 30;
      term = (term * th) >> 30;
      term = term / TermDiv[n];
      if ((n % 2) == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    if (acc > $signed(OneQ30)) begin
      acc = $signed(OneQ30);
    end
    r = ((64'(acc) << 16) + RoundQ29) >> 30;
    if (r > TrigOne) begin
      r = TrigOne;
    end
    return r[rrb_pkg::TrigBits-1:0];
  endfunction

  // Table contents are fixed at elaboration.
  for (genvar k = 0; k <= TRIG_TABLE_DEPTH; k++) begin : g_entry
    assign rom_table[k] = sine_entry(k);
  end

  // Registered reads, held while the pipeline stage is stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_o <= rom_table[addr_a_i];
      data_b_o <= rom_table[addr_b_i];
    end
  end

endmodule

// ===== sv/rotated_rect_bounds_and_corners_top.sv =====
// Top level: rotated rectangle bounding box and corner pipeline.
//
//   Channel | Direction | Payload            | Handshake
//   --------+-----------+--------------------+------------------------------
//   in      | input     | rrb_pkg::rrb_in_t  | in_valid_i, in_stall_o
//   out     | output    | rrb_pkg::rrb_out_t | out_valid_o, out_stall_i
//
// One rectangle is taken per cycle while in_stall_o is low. There are three
// register stages: sine ROM read, multiply, and sum/round/saturate. A result
// is valid on the output once it has passed through all of them.
// Reset clears only the stage valid bits; the payload registers are not reset.
// Every stage holds while the stage after it is full and stalled, so bubbles
// close up and the input stalls only when all three stages are occupied.
module rotated_rect_bounds_and_corners_top #(
  parameter int TRIG_TABLE_DEPTH = rrb_pkg::TrigTableDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rrb_pkg::rrb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rrb_pkg::rrb_out_t out_data_o
);

  localparam int CB       = rrb_pkg::CoordBits;
  localparam int AB       = rrb_pkg::AngleBits;
  localparam int TB       = rrb_pkg::TrigBits;
  localparam int IdxW     = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int PhaseW   = AB - 2;
  localparam int ScaleW   = PhaseW + IdxW;
  localparam int ProdW    = CB - 1 + TB;
  localparam int CenterW  = CB + 2;
  localparam int SumW     = CB + 20;
  localparam int RoundShift = rrb_pkg::TrigFracBits + 1;

  localparam logic signed [SumW-1:0] RoundHalf = SumW'(65536);
  localparam logic signed [SumW-1:0] CoordMax  = {{(SumW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [SumW-1:0] CoordMin  = {{(SumW-CB+1){1'b1}}, {(CB-1){1'b0}}};

  // Handshake and stage enables.
  logic en1;
  logic en2;
  logic en3;
  logic v1_q;
  logic v2_q;
  logic out_valid_q;

  assign en3        = !out_valid_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        out_valid_q <= v2_q;
      end
    end
  end

  // Stage 1: table index from the phase within the quadrant.
  logic [PhaseW-1:0] phase;
  logic [ScaleW-1:0] phase_scaled;
  logic [IdxW-1:0]   idx_sin;
  logic [IdxW-1:0]   idx_cos;

  assign phase        = in_data_i.angle[PhaseW-1:0];
  assign phase_scaled = ScaleW'(phase) * ScaleW'(TRIG_TABLE_DEPTH);
  assign idx_sin      = phase_scaled[ScaleW-1:PhaseW];
  assign idx_cos      = IdxW'(TRIG_TABLE_DEPTH) - idx_sin;

  rrb_pkg::rrb_in_t  s1_item_q;
  logic [TB-1:0]     trig_a;
  logic [TB-1:0]     trig_b;

  rrb_trig_rom #(
    .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)
  ) u_trig_rom (
    .clk_i   (clk_i),
    .en_i    (en1),
    .addr_a_i(idx_sin),
    .addr_b_i(idx_cos),
    .data_a_o(trig_a),
    .data_b_o(trig_b)
  );

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_item_q <= in_data_i;
    end
  end

  // Stage 2: quadrant folding, center and the four magnitude products.
  logic [1:0]               quadrant;
  logic [TB-1:0]            abs_sin;
  logic [TB-1:0]            abs_cos;
  logic signed [CenterW-1:0] cx_d;
  logic signed [CenterW-1:0] cy_d;

  assign quadrant = s1_item_q.angle[AB-1:AB-2];
  assign abs_sin  = quadrant[0] ? trig_b : trig_a;
  assign abs_cos  = quadrant[0] ? trig_a : trig_b;
  assign cx_d = ($signed({{2{s1_item_q.rect_x[CB-1]}}, s1_item_q.rect_x}) <<< 1)
              + $signed({3'b000, s1_item_q.rect_width});
  assign cy_d = ($signed({{2{s1_item_q.rect_y[CB-1]}}, s1_item_q.rect_y}) <<< 1)
              + $signed({3'b000, s1_item_q.rect_height});

  logic [ProdW-1:0]          p_wc_q;
  logic [ProdW-1:0]          p_hs_q;
  logic [ProdW-1:0]          p_ws_q;
  logic [ProdW-1:0]          p_hc_q;
  logic signed [CenterW-1:0] cx_q;
  logic signed [CenterW-1:0] cy_q;
  logic                      sin_neg_q;
  logic                      cos_neg_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      p_wc_q    <= ProdW'(s1_item_q.rect_width)  * ProdW'(abs_cos);
      p_hs_q    <= ProdW'(s1_item_q.rect_height) * ProdW'(abs_sin);
      p_ws_q    <= ProdW'(s1_item_q.rect_width)  * ProdW'(abs_sin);
      p_hc_q    <= ProdW'(s1_item_q.rect_height) * ProdW'(abs_cos);
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      sin_neg_q <= quadrant[1];
      cos_neg_q <= quadrant[1] ^ quadrant[0];
    end
  end

  // Round a Q.25 value to Q.8, ties toward plus infinity, then clamp.
  function automatic logic signed [CB-1:0] pack_coord(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    r = (v + RoundHalf) >>> RoundShift;
    if (r > CoordMax) begin
      r = CoordMax;
    end else if (r < CoordMin) begin
      r = CoordMin;
    end
    return r[CB-1:0];
  endfunction

  function automatic logic [CB-2:0] pack_size(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    r = (v + RoundHalf) >>> RoundShift;
    if (r > CoordMax) begin
      r = CoordMax;
    end else if (r < 0) begin
      r = '0;
    end
    return r[CB-2:0];
  endfunction

  // Stage 3: signed terms, box extents and corner sums.
  logic signed [SumW-1:0] cx25;
  logic signed [SumW-1:0] cy25;
  logic signed [SumW-1:0] ext_x;
  logic signed [SumW-1:0] ext_y;
  logic signed [SumW-1:0] t_wc;
  logic signed [SumW-1:0] t_hs;
  logic signed [SumW-1:0] t_ws;
  logic signed [SumW-1:0] t_hc;
  rrb_pkg::rrb_out_t      result_d;
  rrb_pkg::rrb_out_t      out_data_q;

  assign cx25  = $signed({{(SumW-CenterW-16){cx_q[CenterW-1]}}, cx_q, 16'b0});
  assign cy25  = $signed({{(SumW-CenterW-16){cy_q[CenterW-1]}}, cy_q, 16'b0});
  assign ext_x = $signed({{(SumW-ProdW){1'b0}}, p_wc_q})
               + $signed({{(SumW-ProdW){1'b0}}, p_hs_q});
  assign ext_y = $signed({{(SumW-ProdW){1'b0}}, p_ws_q})
               + $signed({{(SumW-ProdW){1'b0}}, p_hc_q});

  always_comb begin
    t_wc = $signed({{(SumW-ProdW){1'b0}}, p_wc_q});
    t_hs = $signed({{(SumW-ProdW){1'b0}}, p_hs_q});
    t_ws = $signed({{(SumW-ProdW){1'b0}}, p_ws_q});
    t_hc = $signed({{(SumW-ProdW){1'b0}}, p_hc_q});
    if (cos_neg_q) begin
      t_wc = -t_wc;
      t_hc = -t_hc;
    end
    if (sin_neg_q) begin
      t_hs = -t_hs;
      t_ws = -t_ws;
    end
  end

  always_comb begin
    result_d.bound_x        = pack_coord(cx25 - ext_x);
    result_d.bound_y        = pack_coord(cy25 - ext_y);
    result_d.bound_width    = pack_size(ext_x <<< 1);
    result_d.bound_height   = pack_size(ext_y <<< 1);
    result_d.top_left_x     = pack_coord(cx25 - t_wc + t_hs);
    result_d.top_left_y     = pack_coord(cy25 - t_ws - t_hc);
    result_d.top_right_x    = pack_coord(cx25 + t_wc + t_hs);
    result_d.top_right_y    = pack_coord(cy25 + t_ws - t_hc);
    result_d.bottom_right_x = pack_coord(cx25 + t_wc - t_hs);
    result_d.bottom_right_y = pack_coord(cy25 + t_ws + t_hc);
    result_d.bottom_left_x  = pack_coord(cx25 - t_wc - t_hs);
    result_d.bottom_left_y  = pack_coord(cy25 - t_ws + t_hc);
  end

  // Result register, held while the consumer stalls.
  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_data_q <= result_d;
    end
  end

  assign out_data_o = out_data_q;

endmodule
